/* rtl/volume_interpolation_sampler_top_macros.svh */
// Assertion macros shared by the volume sampler RTL.
// Needs i_clk and i_rst_n in the module that uses them.
`ifndef VOLUME_INTERPOLATION_SAMPLER_TOP_MACROS_SVH
`define VOLUME_INTERPOLATION_SAMPLER_TOP_MACROS_SVH
`ifndef SYNTH
`define VIS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define VIS_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) else $error(msg);
`define VIS_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VIS_ASSERT(lbl, cond, msg)
`define VIS_IMPLY(lbl, pre, post, msg)
`define VIS_NEXT(lbl, pre, post, msg)
`endif
`endif

/* rtl/vis_pkg.sv */
// Shared types and constants of the volume sampler.
// No dependencies.
package vis_pkg;

    localparam int COORD_W   = 16;
    localparam int ADDR_W    = 18;
    localparam int SIZE_W    = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 25;
    localparam int CR_BITS   = 12;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;

    // request class decided at the front
    typedef enum logic [2:0] {
        K_WRITE,
        K_NEAREST,
        K_LINEAR,
        K_CUBIC,
        K_ZERO
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic [ADDR_W-1:0]         addr;
        logic [2:0][COORD_W-1:0]   org;
        logic [2:0][COORD_W-1:0]   coord;
    } t_item;

endpackage

/* rtl/vis_front.sv */
// Front end: configuration registers, request classification, request queue.
// Depends on vis_pkg and the assertion macro header.
`include "volume_interpolation_sampler_top_macros.svh"

module vis_front import vis_pkg::*; #(
    parameter int DIM_MAX    = 64,
    parameter int VOXEL_BITS = 16,
    parameter int FRAC_BITS  = 8,
    localparam int DW        = $clog2(DIM_MAX + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_func,
    input  logic [ADDR_W-1:0]            i_voxel_address,
    input  logic signed [VOXEL_BITS-1:0] i_voxel_value,
    input  logic signed [COORD_W-1:0]    i_coord_x,
    input  logic signed [COORD_W-1:0]    i_coord_y,
    input  logic signed [COORD_W-1:0]    i_coord_z,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [SIZE_W-1:0]            i_cfg_data,
    output logic [2:0][DW-1:0]           o_dim,
    output logic                         o_head_valid,
    output t_item                        o_head,
    output logic [VOXEL_BITS-1:0]        o_head_value,
    input  logic                         i_pop
);

    logic [SIZE_W-1:0]       r_size_x, r_size_y, r_size_z;
    logic [MODE_W-1:0]       r_mode;
    logic [2:0][DW-1:0]      w_dim;
    logic [2:0][COORD_W-1:0] w_coord;
    logic signed [COORD_W-1:0] w_base [3];
    logic [2:0]              w_round;
    logic                    w_fail;
    t_item                   w_item;
    logic                    w_push;

    t_item                   r_q_item [Q_DEPTH];
    logic [VOXEL_BITS-1:0]   r_q_val  [Q_DEPTH];
    logic [Q_PTR_W-1:0]      r_wp, r_rp;
    logic [Q_CNT_W-1:0]      r_cnt;

    function automatic logic [DW-1:0] eff_dim(input logic [SIZE_W-1:0] r);
        logic [DW-1:0] d;
        if (r == '0) begin
            d = DW'(1);
        end else if (int'(r) > DIM_MAX) begin
            d = DW'(DIM_MAX);
        end else begin
            d = DW'(r);
        end
        return d;
    endfunction

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RST;
            r_size_y <= SIZE_RST;
            r_size_z <= SIZE_RST;
            r_mode   <= MODE_LINEAR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_SIZE_Z: r_size_z <= i_cfg_data;
                REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_dim[0] = eff_dim(r_size_x);
    assign w_dim[1] = eff_dim(r_size_y);
    assign w_dim[2] = eff_dim(r_size_z);
    assign o_dim    = w_dim;
    assign w_coord  = {i_coord_z, i_coord_y, i_coord_x};

    // split each axis into floor and fraction, check the cubic window
    always_comb begin
        w_fail = 1'b0;
        for (int a = 0; a < 3; a++) begin
            w_base[a]  = $signed(w_coord[a]) >>> FRAC_BITS;
            w_round[a] = w_coord[a][FRAC_BITS-1];
            if (w_coord[a][COORD_W-1] || (w_base[a] < 2) ||
                ((w_base[a] + 3) > $signed({1'b0, w_dim[a]}))) begin
                w_fail = 1'b1;
            end
        end
    end

    // classify the request and pick the neighborhood origin
    always_comb begin
        w_item       = '0;
        w_item.addr  = i_voxel_address;
        w_item.coord = w_coord;
        if (!i_func) begin
            w_item.kind = K_WRITE;
        end else begin
            case (r_mode)
                MODE_LINEAR: w_item.kind = K_LINEAR;
                MODE_CUBIC:  w_item.kind = w_fail ? K_ZERO : K_CUBIC;
                default:     w_item.kind = K_NEAREST;
            endcase
        end
        for (int a = 0; a < 3; a++) begin
            case (w_item.kind)
                K_NEAREST: w_item.org[a] = w_round[a] ? w_base[a] + COORD_W'(1) : w_base[a];
                K_CUBIC:   w_item.org[a] = w_base[a] - COORD_W'(1);
                default:   w_item.org[a] = w_base[a];
            endcase
        end
    end

    // request queue
    assign busy   = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign w_push = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_item[r_wp] <= w_item;
            r_q_val[r_wp]  <= i_voxel_value;
        end
    end

    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q_item[r_rp];
    assign o_head_value = r_q_val[r_rp];

    `VIS_ASSERT(a_q_cnt_max, r_cnt <= Q_CNT_W'(Q_DEPTH), "request queue count above depth")
    `VIS_IMPLY(a_q_pop_nonempty, i_pop, r_cnt != '0, "pop from empty request queue")
    `VIS_NEXT(a_q_cnt_up, w_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "queue count missed push")

endmodule

/* rtl/vis_back.sv */
// Back end: voxel store, weight setup, corner sequencer and MAC pipeline.
// Depends on vis_pkg and the assertion macro header.
`include "volume_interpolation_sampler_top_macros.svh"

module vis_back import vis_pkg::*; #(
    parameter int DIM_MAX    = 64,
    parameter int VOXEL_BITS = 16,
    parameter int FRAC_BITS  = 8,
    localparam int DW        = $clog2(DIM_MAX + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [2:0][DW-1:0]       i_dim,
    input  logic                     i_head_valid,
    input  t_item                    i_head,
    input  logic [VOXEL_BITS-1:0]    i_head_value,
    output logic                     o_pop,
    output logic                     o_sample_valid,
    output logic signed [OUT_W-1:0]  o_sample_value
);

    localparam int IW      = $clog2(DIM_MAX);
    localparam int WGT_W   = ((FRAC_BITS > CR_BITS) ? FRAC_BITS : CR_BITS) + 2;
    localparam int UW      = 3 * FRAC_BITS + 4;
    localparam int CR_SH   = 3 * FRAC_BITS + 1 - CR_BITS;
    localparam int P1_W    = VOXEL_BITS + WGT_W;
    localparam int P2_W    = P1_W + WGT_W;
    localparam int LO_W    = P2_W / 2;
    localparam int HI_W    = P2_W - LO_W;
    localparam int P3_W    = P2_W + WGT_W;
    localparam int ACC_W   = P3_W + 7;
    localparam int SH_LIN  = 2 * FRAC_BITS;
    localparam int SH_CUB  = 3 * CR_BITS - FRAC_BITS;
    localparam int ZY_W    = 2 * IW;
    localparam int LIN_W   = (3 * IW > ADDR_W) ? 3 * IW : ADDR_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int N_STG   = 8;

    localparam logic signed [UW-1:0]    CR_HALF  = UW'(1 <<< (CR_SH - 1));
    localparam logic signed [UW-1:0]    TWO_S3   = UW'(1 <<< (3 * FRAC_BITS + 1));
    localparam logic signed [WGT_W-1:0] S_ONE    = WGT_W'(1 <<< FRAC_BITS);
    localparam logic signed [WGT_W-1:0] W_ONE    = WGT_W'(1);
    localparam logic signed [ACC_W-1:0] HALF_LIN = ACC_W'(1 <<< (SH_LIN - 1));
    localparam logic signed [ACC_W-1:0] HALF_CUB = ACC_W'(1 <<< (SH_CUB - 1));
    localparam logic signed [ACC_W-1:0] OUT_MAX  = ACC_W'((1 <<< (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN  = ACC_W'(-(1 <<< (OUT_W - 1)));
    localparam logic [1:0] LIM_NEAR = 2'd0;
    localparam logic [1:0] LIM_LIN  = 2'd1;
    localparam logic [1:0] LIM_CUB  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_WGT,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic inb;
    } t_tag;

    t_state                    r_state;
    t_kind                     r_kind;
    logic [2:0][COORD_W-1:0]   r_org;
    logic [FRAC_BITS-1:0]      r_frac [3];
    logic [2*FRAC_BITS-1:0]    r_d2 [3];
    logic [3*FRAC_BITS-1:0]    r_d3 [3];
    logic signed [WGT_W-1:0]   r_w [3][4];
    logic [1:0]                r_ox, r_oy, r_oz, r_lim;
    logic                      r_zero;

    logic signed [UW-1:0]      w_dd [3];
    logic signed [UW-1:0]      w_d2 [3];
    logic signed [UW-1:0]      w_d3 [3];
    logic signed [UW-1:0]      w_u  [3][4];
    logic signed [UW-1:0]      w_r  [3][4];
    logic signed [WGT_W-1:0]   w_wgt [3][4];
    logic [2:0][1:0]           w_off;
    logic signed [COORD_W-1:0] w_idx [3];
    logic [2:0]                w_inb;
    logic                      w_last, w_first;
    logic                      w_mem_we;
    logic [LIN_W-1:0]          w_lin;
    logic signed [VOXEL_BITS-1:0] w_vox;

    t_tag                      r_tag [N_STG];
    logic [IW-1:0]             r_a_idx [3];
    logic signed [WGT_W-1:0]   r_wa [3];
    logic signed [WGT_W-1:0]   r_wb [3];
    logic signed [WGT_W-1:0]   r_wc [3];
    logic signed [WGT_W-1:0]   r_wd [3];
    logic signed [WGT_W-1:0]   r_we1, r_we2, r_wf2;
    logic [ZY_W-1:0]           r_b_zy;
    logic [IW-1:0]             r_b_x;
    logic [ADDR_W-1:0]         r_c_addr;
    logic [VOXEL_BITS-1:0]     r_mem [DEPTH];
    logic [VOXEL_BITS-1:0]     r_rd;
    logic signed [P1_W-1:0]    r_p1;
    logic signed [P2_W-1:0]    r_p2;
    logic signed [LO_W+WGT_W:0] r_lo;
    logic signed [HI_W+WGT_W-1:0] r_hi;
    logic signed [P3_W-1:0]    r_p3;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_i_valid;
    logic signed [ACC_W-1:0]   r_rnd;
    logic                      r_j_valid;
    logic                      r_out_valid;
    logic signed [OUT_W-1:0]   r_out_value;

    // take the next request whenever the engine is free
    assign o_pop    = (r_state == ST_IDLE) && i_head_valid;
    assign w_mem_we = o_pop && (i_head.kind == K_WRITE);

    // per-axis weights: Catmull-Rom from d, d^2, d^3, or linear / nearest
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dd[a] = UW'(r_frac[a]);
            w_d2[a] = UW'(r_d2[a]);
            w_d3[a] = UW'(r_d3[a]);
            w_u[a][0] = (w_d2[a] <<< (FRAC_BITS + 1)) - w_d3[a]
                        - (w_dd[a] <<< (2 * FRAC_BITS));
            w_u[a][1] = (w_d3[a] <<< 1) + w_d3[a] - (w_d2[a] <<< (FRAC_BITS + 2))
                        - (w_d2[a] <<< FRAC_BITS) + TWO_S3;
            w_u[a][2] = (w_d2[a] <<< (FRAC_BITS + 2)) + (w_dd[a] <<< (2 * FRAC_BITS))
                        - (w_d3[a] <<< 1) - w_d3[a];
            w_u[a][3] = w_d3[a] - (w_d2[a] <<< FRAC_BITS);
            for (int i = 0; i < 4; i++) begin
                w_r[a][i] = (w_u[a][i] + CR_HALF) >>> CR_SH;
            end
            for (int i = 0; i < 4; i++) begin
                w_wgt[a][i] = '0;
            end
            case (r_kind)
                K_CUBIC: begin
                    for (int i = 0; i < 4; i++) begin
                        w_wgt[a][i] = WGT_W'(w_r[a][i]);
                    end
                end
                K_LINEAR: begin
                    w_wgt[a][0] = S_ONE - $signed(WGT_W'(r_frac[a]));
                    w_wgt[a][1] = $signed(WGT_W'(r_frac[a]));
                end
                default: begin
                    w_wgt[a][0] = (a == 0) ? S_ONE : W_ONE;
                end
            endcase
        end
    end

    // corner index and bounds for the current offset
    assign w_off   = {r_oz, r_oy, r_ox};
    assign w_last  = (r_ox == r_lim) && (r_oy == r_lim) && (r_oz == r_lim);
    assign w_first = (r_ox == '0) && (r_oy == '0) && (r_oz == '0);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_idx[a] = $signed(r_org[a]) + $signed({{(COORD_W-2){1'b0}}, w_off[a]});
            w_inb[a] = !w_idx[a][COORD_W-1] &&
                       (w_idx[a] < $signed({{(COORD_W-DW){1'b0}}, i_dim[a]}));
        end
    end

    // sequencer: setup of weights, then one corner per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_zero  <= 1'b0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_oz    <= '0;
            r_lim   <= '0;
        end else begin
            r_zero <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_head_valid) begin
                        r_kind <= i_head.kind;
                        r_org  <= i_head.org;
                        for (int a = 0; a < 3; a++) begin
                            r_frac[a] <= i_head.coord[a][FRAC_BITS-1:0];
                        end
                        if (i_head.kind == K_ZERO) begin
                            r_zero <= 1'b1;
                        end else if (i_head.kind != K_WRITE) begin
                            r_state <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    for (int a = 0; a < 3; a++) begin
                        r_d2[a] <= (2*FRAC_BITS)'(r_frac[a]) * (2*FRAC_BITS)'(r_frac[a]);
                    end
                    r_state <= ST_CUBE;
                end
                ST_CUBE: begin
                    for (int a = 0; a < 3; a++) begin
                        r_d3[a] <= (3*FRAC_BITS)'(r_d2[a]) * (3*FRAC_BITS)'(r_frac[a]);
                    end
                    r_state <= ST_WGT;
                end
                ST_WGT: begin
                    r_w  <= w_wgt;
                    r_ox <= '0;
                    r_oy <= '0;
                    r_oz <= '0;
                    case (r_kind)
                        K_LINEAR: r_lim <= LIM_LIN;
                        K_CUBIC:  r_lim <= LIM_CUB;
                        default:  r_lim <= LIM_NEAR;
                    endcase
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (r_ox != r_lim) begin
                        r_ox <= r_ox + 1'b1;
                    end else begin
                        r_ox <= '0;
                        if (r_oy != r_lim) begin
                            r_oy <= r_oy + 1'b1;
                        end else begin
                            r_oy <= '0;
                            r_oz <= r_oz + 1'b1;
                        end
                    end
                    if (w_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_j_valid) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // pipeline control tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N_STG; s++) begin
                r_tag[s] <= '0;
            end
            r_i_valid   <= 1'b0;
            r_j_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tag[0].valid <= (r_state == ST_RUN);
            r_tag[0].first <= w_first;
            r_tag[0].last  <= w_last;
            r_tag[0].inb   <= &w_inb;
            for (int s = 1; s < N_STG; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
            r_i_valid   <= r_tag[N_STG-1].valid && r_tag[N_STG-1].last;
            r_j_valid   <= r_i_valid;
            r_out_valid <= r_j_valid || r_zero;
        end
    end

    // address: z*sy + y, then * sx + x
    assign w_lin = LIN_W'(r_b_zy) * LIN_W'(i_dim[0]) + LIN_W'(r_b_x);

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_a_idx[a] <= w_idx[a][IW-1:0];
            r_wa[a]    <= r_w[a][w_off[a]];
        end
        r_b_zy   <= ZY_W'(r_a_idx[2]) * ZY_W'(i_dim[1]) + ZY_W'(r_a_idx[1]);
        r_b_x    <= r_a_idx[0];
        r_wb     <= r_wa;
        r_c_addr <= w_lin[ADDR_W-1:0];
        r_wc     <= r_wb;
        r_wd     <= r_wc;
    end

    // voxel store, single port use: writes only while the engine is idle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_head.addr] <= i_head_value;
        end
        r_rd <= r_mem[r_c_addr];
    end

    // multiply by three weights, widest product cut in two halves
    assign w_vox = r_tag[3].inb ? $signed(r_rd) : '0;

    always_ff @(posedge i_clk) begin
        r_p1  <= P1_W'(w_vox) * P1_W'(r_wd[0]);
        r_we1 <= r_wd[1];
        r_we2 <= r_wd[2];
        r_p2  <= P2_W'(r_p1) * P2_W'(r_we1);
        r_wf2 <= r_we2;
        r_lo  <= (LO_W+WGT_W+1)'($signed({1'b0, r_p2[LO_W-1:0]}))
                 * (LO_W+WGT_W+1)'(r_wf2);
        r_hi  <= (HI_W+WGT_W)'($signed(r_p2[P2_W-1:LO_W])) * (HI_W+WGT_W)'(r_wf2);
        r_p3  <= (P3_W'(r_hi) <<< LO_W) + P3_W'(r_lo);
    end

    // accumulate, round, saturate
    always_ff @(posedge i_clk) begin
        if (r_tag[N_STG-1].valid) begin
            if (r_tag[N_STG-1].first) begin
                r_acc <= ACC_W'(r_p3);
            end else begin
                r_acc <= r_acc + ACC_W'(r_p3);
            end
        end
        case (r_kind)
            K_LINEAR: r_rnd <= (r_acc + HALF_LIN) >>> SH_LIN;
            K_CUBIC:  r_rnd <= (r_acc + HALF_CUB) >>> SH_CUB;
            default:  r_rnd <= r_acc;
        endcase
        if (r_zero) begin
            r_out_value <= '0;
        end else if (r_rnd > OUT_MAX) begin
            r_out_value <= OUT_W'(OUT_MAX);
        end else if (r_rnd < OUT_MIN) begin
            r_out_value <= OUT_W'(OUT_MIN);
        end else begin
            r_out_value <= OUT_W'(r_rnd);
        end
    end

    assign o_sample_valid = r_out_valid;
    assign o_sample_value = r_out_value;

    `VIS_IMPLY(a_wr_quiet, w_mem_we, !r_tag[0].valid && !r_tag[3].valid && !r_tag[7].valid, "store write during corner reads")
    `VIS_IMPLY(a_acc_active, r_i_valid, (r_state == ST_RUN) || (r_state == ST_DRAIN), "sum done outside a sample")
    `VIS_IMPLY(a_round_drain, r_j_valid, r_state == ST_DRAIN, "rounded sum without a pending sample")

endmodule

/* rtl/volume_interpolation_sampler_top.sv */
// Writes and cubic samples outside the window are taken at pop; the back end stays idle.
// A sample holds the back end through pop, setup (ST_SQ, ST_CUBE, ST_WGT), N store reads
// (N = 1 nearest, 8 trilinear, 64 tricubic) and the pipeline drain, then it strobes.
// A two-entry request queue accepts new requests while a sample runs; busy when full.
// Results strobe for one cycle and cannot be stalled. Synchronous active-low reset
// clears control and configuration; the voxel store is not cleared.
// Top level of the volume sampler: front end with queue, back end with store.
// Depends on vis_pkg, vis_front, vis_back.
module volume_interpolation_sampler_top import vis_pkg::*; #(
    parameter int DIM_MAX    = 64,
    parameter int VOXEL_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_func,
    input  logic [ADDR_W-1:0]            i_voxel_address,
    input  logic signed [VOXEL_BITS-1:0] i_voxel_value,
    input  logic signed [COORD_W-1:0]    i_coord_x,
    input  logic signed [COORD_W-1:0]    i_coord_y,
    input  logic signed [COORD_W-1:0]    i_coord_z,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [SIZE_W-1:0]            i_cfg_data,
    output logic                         o_sample_valid,
    output logic signed [OUT_W-1:0]      o_sample_value
);

    localparam int DW = $clog2(DIM_MAX + 1);

    logic [2:0][DW-1:0]    w_dim;
    logic                  w_head_valid;
    t_item                 w_head;
    logic [VOXEL_BITS-1:0] w_head_value;
    logic                  w_pop;

    vis_front #(
        .DIM_MAX    (DIM_MAX),
        .VOXEL_BITS (VOXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_voxel_address (i_voxel_address),
        .i_voxel_value   (i_voxel_value),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_dim           (w_dim),
        .o_head_valid    (w_head_valid),
        .o_head          (w_head),
        .o_head_value    (w_head_value),
        .i_pop           (w_pop)
    );

    vis_back #(
        .DIM_MAX    (DIM_MAX),
        .VOXEL_BITS (VOXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dim          (w_dim),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .i_head_value   (w_head_value),
        .o_pop          (w_pop),
        .o_sample_valid (o_sample_valid),
        .o_sample_value (o_sample_value)
    );

endmodule
